/* hdl/ue2u_pkg.sv */
package ue2u_pkg;

  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned LEN_W           = 16;
  localparam int unsigned LENGTH_BITS_DEF = 16;
  localparam int unsigned HOLD_DEPTH      = 6;

  localparam logic [LEN_W-1:0]  CAP_RESET = 16'hFFFF;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_LOW_U  = 8'h75;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ENC
  } state_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SKIP,
    CMD_LITERAL,
    CMD_ENCODE,
    CMD_ENC_EMIT
  } cmd_e;

  typedef struct packed {
    logic dropping;
    logic prefix_ok;
    logic full;
    logic last;
    logic single;
    logic enc_final;
    logic slot_free;
    logic overflow;
  } status_t;

  function automatic logic is_hex(input logic [BYTE_W-1:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  function automatic logic [3:0] hex_val(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] v;
    if (c inside {[8'h30:8'h39]}) begin
      v = c - 8'h30;
    end else if (c inside {[8'h61:8'h66]}) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

endpackage

/* hdl/ue2u_in_if.sv */
interface ue2u_in_if import ue2u_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              is_last;

  modport source (output valid, output in_byte, output is_last, input ready);
  modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

/* hdl/ue2u_out_if.sv */
interface ue2u_out_if import ue2u_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              byte_valid;
  logic              end_of_string;
  logic              overflow_error;
  logic [LEN_W-1:0]  out_length;

  modport source (output valid, output out_byte, output byte_valid, output end_of_string,
                  output overflow_error, output out_length, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input end_of_string,
                  input overflow_error, input out_length, output ready);
endinterface

/* hdl/ue2u_cfg_if.sv */
interface ue2u_cfg_if import ue2u_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] output_capacity;

  modport source (output valid, output output_capacity, input ready);
  modport sink   (input valid, input output_capacity, output ready);
endinterface

/* hdl/ue2u_ctrl.sv */
module ue2u_ctrl import ue2u_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_e    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = CMD_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (status_i.dropping) begin
            cmd_o = CMD_SKIP;
          end else begin
            cmd_o   = CMD_LOAD;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (status_i.prefix_ok && status_i.full) begin
          cmd_o   = CMD_ENCODE;
          state_d = ST_ENC;
        end else if (status_i.prefix_ok && !status_i.last) begin
          state_d = ST_IDLE;
        end else if (status_i.slot_free) begin
          cmd_o = CMD_LITERAL;
          if (status_i.overflow || status_i.single) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_ENC: begin
        if (status_i.slot_free) begin
          cmd_o = CMD_ENC_EMIT;
          if (status_i.overflow || status_i.enc_final) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* hdl/ue2u_datapath.sv */
module ue2u_datapath import ue2u_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_e              cmd_i,
  output status_t           status_o,
  input  logic [BYTE_W-1:0] in_byte_i,
  input  logic              is_last_i,
  ue2u_cfg_if.sink          cfg_i,
  ue2u_out_if.source        out_o
);

  localparam int unsigned CMP_W = (LENGTH_BITS > LEN_W) ? LENGTH_BITS : LEN_W;

  logic [BYTE_W-1:0]      hold_q [HOLD_DEPTH];
  logic [2:0]             cnt_q;
  logic                   last_q;
  logic                   dropping_q;
  logic [LENGTH_BITS-1:0] written_q;
  logic [LEN_W-1:0]       cap_q;
  logic [BYTE_W-1:0]      enc_q [3];
  logic [1:0]             enc_idx_q;
  logic [1:0]             enc_top_q;

  logic                   out_valid_q;
  logic [BYTE_W-1:0]      out_byte_q;
  logic                   byte_valid_q;
  logic                   eos_q;
  logic                   err_q;
  logic [LEN_W-1:0]       out_len_q;

  logic                   prefix_ok;
  logic                   overflow;
  logic                   slot_free;
  logic                   emit;
  logic                   end_data;
  logic [LENGTH_BITS-1:0] written_inc;
  logic [BYTE_W-1:0]      emit_byte;
  logic [15:0]            cp;
  logic [BYTE_W-1:0]      enc_d [3];
  logic [1:0]             enc_top_d;

  always_comb begin
    prefix_ok = 1'b1;
    for (int k = 0; k < HOLD_DEPTH; k++) begin
      if (k < int'(cnt_q)) begin
        if (k == 0) begin
          if (hold_q[k] != CH_BSLASH) prefix_ok = 1'b0;
        end else if (k == 1) begin
          if (hold_q[k] != CH_LOW_U) prefix_ok = 1'b0;
        end else if (!is_hex(hold_q[k])) begin
          prefix_ok = 1'b0;
        end
      end
    end
  end

  always_comb begin
    cp        = {hex_val(hold_q[2]), hex_val(hold_q[3]), hex_val(hold_q[4]), hex_val(hold_q[5])};
    enc_d[0]  = cp[7:0];
    enc_d[1]  = 8'h80 | {2'b00, cp[5:0]};
    enc_d[2]  = 8'h80 | {2'b00, cp[5:0]};
    enc_top_d = 2'd0;
    if (cp < 16'h0080) begin
      enc_top_d = 2'd0;
    end else if (cp < 16'h0800) begin
      enc_d[0]  = 8'hC0 | {3'b000, cp[10:6]};
      enc_top_d = 2'd1;
    end else begin
      enc_d[0]  = 8'hE0 | {4'b0000, cp[15:12]};
      enc_d[1]  = 8'h80 | {2'b00, cp[11:6]};
      enc_top_d = 2'd2;
    end
  end

  assign overflow    = CMP_W'(written_q) >= CMP_W'(cap_q);
  assign slot_free   = !out_valid_q || out_o.ready;
  assign emit        = (cmd_i == CMD_LITERAL) || (cmd_i == CMD_ENC_EMIT);
  assign written_inc = written_q + LENGTH_BITS'(1);
  assign emit_byte   = (cmd_i == CMD_LITERAL) ? hold_q[0] : enc_q[enc_idx_q];
  assign end_data    = last_q && ((cmd_i == CMD_LITERAL) ? (cnt_q == 3'd1)
                                                         : (enc_idx_q == enc_top_q));

  assign status_o.dropping  = dropping_q;
  assign status_o.prefix_ok = prefix_ok;
  assign status_o.full      = (cnt_q == 3'(HOLD_DEPTH));
  assign status_o.last      = last_q;
  assign status_o.single    = (cnt_q == 3'd1);
  assign status_o.enc_final = (enc_idx_q == enc_top_q);
  assign status_o.slot_free = slot_free;
  assign status_o.overflow  = overflow;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      written_q   <= '0;
      dropping_q  <= 1'b0;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
      enc_idx_q   <= '0;
    end else begin
      if (cfg_i.valid) begin
        cap_q <= cfg_i.output_capacity;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i)
        CMD_LOAD: begin
          cnt_q <= cnt_q + 3'd1;
        end
        CMD_SKIP: begin
          if (is_last_i) dropping_q <= 1'b0;
        end
        CMD_ENCODE: begin
          cnt_q     <= '0;
          enc_idx_q <= '0;
        end
        CMD_LITERAL, CMD_ENC_EMIT: begin
          if (overflow) begin
            cnt_q      <= '0;
            written_q  <= '0;
            dropping_q <= !last_q;
          end else begin
            written_q <= end_data ? '0 : written_inc;
            if (cmd_i == CMD_LITERAL) begin
              cnt_q <= cnt_q - 3'd1;
            end else begin
              enc_idx_q <= enc_idx_q + 2'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: begin
        hold_q[cnt_q] <= in_byte_i;
        last_q        <= is_last_i;
      end
      CMD_ENCODE: begin
        enc_q     <= enc_d;
        enc_top_q <= enc_top_d;
      end
      CMD_LITERAL: begin
        for (int k = 0; k < HOLD_DEPTH - 1; k++) begin
          hold_q[k] <= hold_q[k+1];
        end
      end
      default: begin
      end
    endcase
    if (emit) begin
      if (overflow) begin
        out_byte_q   <= '0;
        byte_valid_q <= 1'b0;
        eos_q        <= 1'b1;
        err_q        <= 1'b1;
        out_len_q    <= LEN_W'(CMP_W'(written_q));
      end else begin
        out_byte_q   <= emit_byte;
        byte_valid_q <= 1'b1;
        eos_q        <= end_data;
        err_q        <= 1'b0;
        out_len_q    <= LEN_W'(CMP_W'(written_inc));
      end
    end
  end

  assign cfg_i.ready          = 1'b1;
  assign out_o.valid          = out_valid_q;
  assign out_o.out_byte       = out_byte_q;
  assign out_o.byte_valid     = byte_valid_q;
  assign out_o.end_of_string  = eos_q;
  assign out_o.overflow_error = err_q;
  assign out_o.out_length     = out_len_q;

endmodule

/* hdl/unicode_escape_to_utf8.sv */
// channel  | modport | payload
// ---------+---------+----------------------------------------------------------------
// cfg_i    | sink    | output_capacity[15:0]
// in_i     | sink    | in_byte[7:0], is_last
// out_o    | source  | out_byte[7:0], byte_valid, end_of_string, overflow_error,
//          |         | out_length[15:0]
//
// A plain byte is accepted, then scanned and emitted. A held escape byte is accepted and scanned.
// A full escape is encoded, then emitted as UTF-8 bytes; each rescanned byte adds a scan.
// The scan loop emits at most one byte per cycle into a single output register and
// waits while that register is full and out_o.ready is low; no item is taken meanwhile.
// Reset: capacity 65535, nothing held, counters zero; no clearing pass.
module unicode_escape_to_utf8 import ue2u_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ue2u_cfg_if.sink   cfg_i,
  ue2u_in_if.sink    in_i,
  ue2u_out_if.source out_o
);

  cmd_e    cmd;
  status_t status;

  ue2u_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ue2u_datapath #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .status_o  (status),
    .in_byte_i (in_i.in_byte),
    .is_last_i (in_i.is_last),
    .cfg_i     (cfg_i),
    .out_o     (out_o)
  );

endmodule

/* test/testbench.sv */
module testbench;
  import ue2u_pkg::*;

  localparam int          LIMIT_CYCLES = 400000;
  localparam int          SETTLE       = 16;
  localparam int          LONG_HOLD    = 150;
  localparam int          RAND_ITEMS   = 220;
  localparam int          CALM_ITEMS   = 60;
  localparam logic [7:0]  CH_0         = 8'h30;
  localparam logic [7:0]  CH_9         = 8'h39;
  localparam logic [7:0]  CH_UA        = 8'h41;
  localparam logic [7:0]  CH_UF        = 8'h46;
  localparam logic [7:0]  CH_UG        = 8'h47;
  localparam logic [7:0]  CH_LA        = 8'h61;
  localparam logic [7:0]  CH_LB        = 8'h62;
  localparam logic [7:0]  CH_LF        = 8'h66;
  localparam logic [7:0]  CH_LZ        = 8'h7A;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              end_of_string;
    logic              overflow_error;
    logic [LEN_W-1:0]  out_length;
  } utf8_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ue2u_cfg_if cap_ch ();
  ue2u_in_if  src_ch ();
  ue2u_out_if res_ch ();

  unicode_escape_to_utf8 dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cap_ch),
    .in_i   (src_ch),
    .out_o  (res_ch)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // decoder state as seen from outside
  logic [4:0][7:0]  esc_held   = '0;
  int               esc_held_n = 0;
  logic [LEN_W-1:0] out_count  = '0;
  bit               skip_rest  = 1'b0;
  logic [LEN_W-1:0] cap_limit  = CAP_RESET;
  utf8_res_t        utf8_exp_q[$];

  logic [7:0] text_q[$];
  int         n_errors      = 0;
  int         n_cycles      = 0;
  int         live_items    = 0;
  int         hold_cnt      = 0;
  bit         idle_on       = 1'b1;
  int         gap_pct       = 20;
  bit         hold_long_req = 1'b0;

  function automatic bit hex_digit(input logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UF) ||
           (c >= CH_LA && c <= CH_LF);
  endfunction

  function automatic logic [3:0] nibble(input logic [7:0] c);
    logic [7:0] v;
    if (c <= CH_9) begin
      v = c - CH_0;
    end else if (c >= CH_LA) begin
      v = c - CH_LA + 8'd10;
    end else begin
      v = c - CH_UA + 8'd10;
    end
    return v[3:0];
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < 4'd10) return CH_0 + {4'd0, v};
    return (upper ? CH_UA : CH_LA) + {4'd0, v} - 8'd10;
  endfunction

  function automatic bit escape_prefix(input logic [5:0][7:0] w, input int n);
    for (int k = 0; k < n; k++) begin
      if (k == 0 && w[k] != CH_BSLASH) return 1'b0;
      if (k == 1 && w[k] != CH_LOW_U) return 1'b0;
      if (k >= 2 && !hex_digit(w[k])) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit emit_byte(input logic [7:0] b);
    utf8_res_t r;
    r = '0;
    if (out_count >= cap_limit) begin
      r.end_of_string  = 1'b1;
      r.overflow_error = 1'b1;
      r.out_length     = out_count;
      utf8_exp_q.push_back(r);
      return 1'b0;
    end
    out_count    = out_count + 1'b1;
    r.out_byte   = b;
    r.byte_valid = 1'b1;
    r.out_length = out_count;
    utf8_exp_q.push_back(r);
    return 1'b1;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input bit last);
    logic [5:0][7:0] win;
    logic [2:0][7:0] enc;
    logic [15:0]     cp;
    utf8_res_t       r;
    int              n, len, mark;
    bit              ok;
    if (skip_rest) begin
      if (last) skip_rest = 1'b0;
      return;
    end
    win      = '0;
    win[4:0] = esc_held;
    n        = esc_held_n;
    win[n]   = b;
    n++;
    mark = utf8_exp_q.size();
    ok   = 1'b1;
    while (n > 0 && ok) begin
      if (n == 6 && escape_prefix(win, n)) begin
        cp = {nibble(win[2]), nibble(win[3]), nibble(win[4]), nibble(win[5])};
        if (cp < 16'h0080) begin
          enc[0] = cp[7:0];
          len    = 1;
        end else if (cp < 16'h0800) begin
          enc[0] = {3'b110, cp[10:6]};
          enc[1] = {2'b10, cp[5:0]};
          len    = 2;
        end else begin
          enc[0] = {4'b1110, cp[15:12]};
          enc[1] = {2'b10, cp[11:6]};
          enc[2] = {2'b10, cp[5:0]};
          len    = 3;
        end
        n = 0;
        for (int j = 0; j < len && ok; j++) ok = emit_byte(enc[j]);
      end else if (escape_prefix(win, n) && !last) begin
        break;
      end else begin
        ok  = emit_byte(win[0]);
        win = win >> 8;
        n--;
      end
    end
    if (!ok) begin
      esc_held   = '0;
      esc_held_n = 0;
      out_count  = '0;
      skip_rest  = !last;
      return;
    end
    esc_held   = win[4:0];
    esc_held_n = n;
    if (last) begin
      if (utf8_exp_q.size() > mark) begin
        r = utf8_exp_q.pop_back();
        r.end_of_string = 1'b1;
        utf8_exp_q.push_back(r);
      end
      esc_held   = '0;
      esc_held_n = 0;
      out_count  = '0;
    end
  endfunction

  task automatic send_char(input logic [7:0] b, input bit last);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 99) < gap_pct) begin
      src_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    src_ch.valid   <= 1'b1;
    src_ch.in_byte <= b;
    src_ch.is_last <= last;
    @(posedge clk_i);
    while (!src_ch.ready) @(posedge clk_i);
    if (!skip_rest) live_items++;
    decode_byte(b, last);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  // keep: how many bytes of the six-byte escape to push
  task automatic push_escape(input logic [15:0] cp, input int mix, input int keep);
    logic [5:0][7:0] esc;
    esc[0] = CH_BSLASH;
    esc[1] = CH_LOW_U;
    for (int k = 0; k < 4; k++) begin
      esc[2 + k] = hex_char(cp[15 - 4*k -: 4], mix > 1 ? bit'($urandom_range(0, 1)) : mix == 1);
    end
    for (int k = 0; k < keep; k++) text_q.push_back(esc[k]);
  endtask

  function automatic logic [15:0] pick_code();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 16'h007F));
      1: return 16'($urandom_range(16'h0080, 16'h07FF));
      2: return 16'($urandom_range(16'h0800, 16'hFFFF));
      default: begin
        case ($urandom_range(0, 5))
          0: return 16'h0000;
          1: return 16'h007F;
          2: return 16'h0080;
          3: return 16'h07FF;
          4: return 16'h0800;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  // dropped or held bytes leave no result, so give the block time to settle
  task automatic wait_quiet();
    @(negedge clk_i);
    src_ch.valid <= 1'b0;
    while (utf8_exp_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [LEN_W-1:0] v);
    wait_quiet();
    @(negedge clk_i);
    cap_ch.valid           <= 1'b1;
    cap_ch.output_capacity <= v;
    @(posedge clk_i);
    while (!cap_ch.ready) @(posedge clk_i);
    cap_limit = v;
    @(negedge clk_i);
    cap_ch.valid <= 1'b0;
  endtask

  task automatic test_escapes();
    text_q.push_back(8'h00);
    push_escape(16'h007F, 0, 6);
    push_escape(16'hDA0F, 1, 6);
    text_q.push_back(8'hFF);
    send_text();
  endtask

  // bad digit forces a rescan; unfinished escape at the end goes out literally
  task automatic test_broken_escapes();
    push_escape(16'h1000, 0, 3);
    text_q.push_back(CH_UG);
    push_escape(16'h1000, 0, 3);
    send_text();
  endtask

  task automatic test_overflow();
    set_capacity(16'd2);
    text_q.push_back(CH_UA);
    push_escape(16'h07FF, 2, 6);
    text_q.push_back(CH_LZ);
    text_q.push_back(CH_LZ);
    send_text();
    set_capacity(16'd0);
    text_q.push_back(CH_LA);
    text_q.push_back(CH_LB);
    send_text();
  endtask

  task automatic test_backpressure();
    set_capacity(CAP_RESET);
    gap_pct       = 0;
    hold_long_req = 1'b1;
    for (int i = 0; i < 24; i++) text_q.push_back(8'($urandom_range(0, 255)));
    send_text();
    wait_quiet();
  endtask

  task automatic test_random_strings();
    int start, strings, ntok, r;
    start   = live_items;
    strings = 0;
    while (live_items - start < RAND_ITEMS) begin
      if (strings % 6 == 5) begin
        r = $urandom_range(0, 7);
        set_capacity(r == 0 ? 16'd0 : r < 3 ? CAP_RESET : 16'($urandom_range(1, 24)));
      end
      idle_on = (live_items - start < RAND_ITEMS - CALM_ITEMS);
      gap_pct = $urandom_range(0, 40);
      ntok    = $urandom_range(1, 5);
      for (int t = 0; t < ntok; t++) begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          push_escape(pick_code(), 2, 6);
        end else if (r < 55) begin
          push_escape(pick_code(), 2, $urandom_range(1, 5));
          if (t < ntok - 1) text_q.push_back(8'($urandom_range(0, 255)));
        end else if (r < 85) begin
          text_q.push_back(8'($urandom_range(0, 255)));
        end else if (r < 90) begin
          text_q.push_back(CH_BSLASH);
        end else if (r < 95) begin
          text_q.push_back(CH_LOW_U);
        end else begin
          text_q.push_back(hex_char(4'($urandom_range(0, 15)), bit'($urandom_range(0, 1))));
        end
      end
      send_text();
      strings++;
    end
    wait_quiet();
  endtask

  initial begin : rx_ready
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_long_req) begin
        res_ch.ready <= 1'b0;
        for (hold_cnt = 1; hold_cnt < LONG_HOLD; hold_cnt++) @(negedge clk_i);
        hold_long_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 12)) @(negedge clk_i);
      end else begin
        res_ch.ready <= 1'b1;
        repeat ($urandom_range(0, 20)) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    utf8_res_t got, want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got = {res_ch.out_byte, res_ch.byte_valid, res_ch.end_of_string,
             res_ch.overflow_error, res_ch.out_length};
      if (utf8_exp_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result byte %h valid %b eos %b err %b len %0d", $time,
                 got.out_byte, got.byte_valid, got.end_of_string, got.overflow_error,
                 got.out_length);
      end else begin
        want = utf8_exp_q.pop_front();
        if (got !== want) begin
          n_errors++;
          $display("%0t: expected byte %h valid %b eos %b err %b len %0d, got byte %h valid %b eos %b err %b len %0d",
                   $time, want.out_byte, want.byte_valid, want.end_of_string,
                   want.overflow_error, want.out_length, got.out_byte, got.byte_valid,
                   got.end_of_string, got.overflow_error, got.out_length);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > LIMIT_CYCLES) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    src_ch.valid           = 1'b0;
    src_ch.in_byte         = '0;
    src_ch.is_last         = 1'b0;
    cap_ch.valid           = 1'b0;
    cap_ch.output_capacity = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_escapes();
    test_broken_escapes();
    test_overflow();
    test_backpressure();
    test_random_strings();
    if (n_errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
